@@ src/clock_page_replacement_core_defines.svh @@
// ----------------------------------------------------------------------------
// Clock page replacement core: assertion macros
// Concurrent checks used by the core, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CPR_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("cpr check failed");

// next-cycle implication
`define CPR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("cpr check failed");

`else

`define CPR_ASSERT_SAME(label, clk, rst_n, a, b)
`define CPR_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

@@ src/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement package
// Sizes, outcome codes and the control/status bundles shared by the core.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // frame store geometry
    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 10;
    localparam int SLOT_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // port field widths
    localparam int IN_PAGE_BITS  = 10;
    localparam int OUT_SLOT_BITS = 3;
    localparam int OUTCOME_BITS  = 2;

    // what happened to the referenced page
    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_HIT     = 2'd0,
        OUT_FILL    = 2'd1,
        OUT_REPLACE = 2'd2,
        OUT_CLEAR   = 2'd3
    } t_outcome;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture page, restart scan
        logic scan;     // examine one frame
        logic update;   // commit the decision
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } t_stat;

endpackage

@@ src/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement controller
// Sequences load, frame scan and update; drives busy and the result strobe.
// ----------------------------------------------------------------------------
module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy,
    output logic  o_strobe
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe;
    logic   accept;

    // a new word can be taken while idle or during the update cycle
    assign busy   = (r_state == S_SCAN);
    assign accept = start && !busy;

    assign o_cmd.load   = accept;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.update = (r_state == S_UPDATE);
    assign o_strobe     = r_strobe;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_last) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = start ? S_SCAN : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_UPDATE);
        end
    end

endmodule

@@ src/cpr_datapath.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement datapath
// Frame store, one-frame-per-cycle scan and the replacement update.
// ----------------------------------------------------------------------------
module cpr_datapath
    import cpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [IN_PAGE_BITS-1:0]  i_page_number,
    output t_stat                    o_stat,
    output logic [OUT_SLOT_BITS-1:0] o_slot,
    output logic [OUTCOME_BITS-1:0]  o_outcome
);

    // frame store: a page number only counts in the hit compare once its valid bit is set
    logic [PAGE_BITS-1:0] r_frame_page [FRAMES];
    logic [FRAMES-1:0]    r_valid;
    logic [FRAMES-1:0]    r_ref;

    // current reference and scan bookkeeping
    logic [PAGE_BITS-1:0] r_page;
    logic [SLOT_BITS-1:0] r_idx;
    logic                 r_hit_found, r_emp_found, r_clr_found;
    logic [SLOT_BITS-1:0] r_hit_idx, r_emp_idx, r_clr_idx;

    // result registers
    logic [OUT_SLOT_BITS-1:0] r_slot;
    t_outcome                 r_outcome;

    logic                 hit_now;
    logic [SLOT_BITS-1:0] sel_idx;
    t_outcome             sel_outcome;
    logic                 do_load;

    assign o_stat.scan_last = (r_idx == SLOT_BITS'(FRAMES - 1));
    assign o_slot           = r_slot;
    assign o_outcome        = r_outcome;

    // compare the frame under the scan pointer
    assign hit_now = r_valid[r_idx] && (r_frame_page[r_idx] == r_page);

    // pick the case in priority order
    always_comb begin
        sel_idx     = '0;
        sel_outcome = OUT_CLEAR;
        do_load     = 1'b1;
        priority if (r_hit_found) begin
            sel_idx     = r_hit_idx;
            sel_outcome = OUT_HIT;
            do_load     = 1'b0;
        end else if (r_emp_found) begin
            sel_idx     = r_emp_idx;
            sel_outcome = OUT_FILL;
        end else if (r_clr_found) begin
            sel_idx     = r_clr_idx;
            sel_outcome = OUT_REPLACE;
        end
    end

    // scan pointer and first-match trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_hit_found <= 1'b0;
            r_emp_found <= 1'b0;
            r_clr_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx       <= '0;
            r_hit_found <= 1'b0;
            r_emp_found <= 1'b0;
            r_clr_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + SLOT_BITS'(1);
            if (!r_hit_found && hit_now) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_idx;
            end
            if (!r_emp_found && !r_valid[r_idx]) begin
                r_emp_found <= 1'b1;
                r_emp_idx   <= r_idx;
            end
            if (!r_clr_found && !r_ref[r_idx]) begin
                r_clr_found <= 1'b1;
                r_clr_idx   <= r_idx;
            end
        end
    end

    // captured page; bits above PAGE_BITS are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= PAGE_BITS'(i_page_number);
        end
    end

    // valid and reference bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ref   <= '0;
        end else if (i_cmd.update) begin
            if (do_load) begin
                r_valid[sel_idx] <= 1'b1;
            end
            if (sel_outcome == OUT_CLEAR) begin
                r_ref <= '0;
            end else begin
                r_ref[sel_idx] <= 1'b1;
            end
        end
    end

    // page store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && do_load) begin
            r_frame_page[sel_idx] <= r_page;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_slot    <= OUT_SLOT_BITS'(sel_idx);
            r_outcome <= sel_outcome;
        end
    end

endmodule

@@ src/clock_page_replacement_core.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement core
// Places each page reference among the frames and reports slot and outcome.
// ----------------------------------------------------------------------------
// A reference is taken when start is high and busy is low. The core then
// scans the frames one per cycle and commits the decision in the update
// state; busy stays high while the scan runs, so a new reference cannot be
// taken until the serial frame scan is through. The result word appears on
// o_slot/o_outcome with o_strobe high for exactly one cycle and holds there
// until the next update; o_strobe is registered from the update state. There
// is no output backpressure: the receiver must take every strobed word.
// busy is low during the update cycle, so the next start may overlap it.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_core_defines.svh"

module clock_page_replacement_core
    import cpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [IN_PAGE_BITS-1:0]  i_page_number,
    output logic                     busy,
    output logic                     o_strobe,
    output logic [OUT_SLOT_BITS-1:0] o_slot,
    output logic [OUTCOME_BITS-1:0]  o_outcome
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    cpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // frame store and scan
    cpr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_page_number (i_page_number),
        .o_stat        (stat),
        .o_slot        (o_slot),
        .o_outcome     (o_outcome)
    );

    // checks
    `CPR_ASSERT_NEXT(a_accept_scans, i_clk, i_rst_n, start && !busy, busy)
    `CPR_ASSERT_NEXT(a_update_strobes, i_clk, i_rst_n, cmd.update, o_strobe)
    `CPR_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `CPR_ASSERT_SAME(a_clear_slot0, i_clk, i_rst_n, o_strobe && (o_outcome == OUT_CLEAR), o_slot == '0)

endmodule
